@@ rtl/core/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Node status codes and shared types for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	typedef enum logic [1:0] {
		ST_ABSENT = 2'd0,
		ST_FREE   = 2'd1,
		ST_ALLOC  = 2'd2,
		ST_SPLIT  = 2'd3
	} node_st_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam int unsigned REQ_W = 16;
	localparam int unsigned OFF_W = 15;

endpackage

@@ rtl/core/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [bba_pkg::REQ_W-1:0]   req_size;
	logic [bba_pkg::OFF_W-1:0]   free_offset;
	modport source (output valid, op, req_size, free_offset, input ready);
	modport sink (input valid, op, req_size, free_offset, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        success;
	logic [bba_pkg::OFF_W-1:0]   block_offset;
	modport source (output valid, success, block_offset, input ready);
	modport sink (input valid, success, block_offset, output ready);
endinterface

@@ rtl/core/buddy_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator over a region of MIN_BLOCK_BYTES << (LEVELS-1) bytes.
// ----------------------------------------------------------------------------
// One request at a time; the block is not ready while a request is in progress.
// A sequencer walks the node store through one write port and one registered
// read port. Allocate first rounds the size to a target level, one level at a
// time. It then scans from the target level toward the root, reading one node
// at a time. It splits the free block it finds down to the target with three
// writes per level (the node, then its two children), then marks the target
// node allocated. Free probes one node per level from the root downward, then
// merges upward while the buddy is free. Each response then holds in a result
// state until it is taken. After reset a clearing pass over every node runs
// before the first request is taken.
module buddy_block_allocator_core #(
	parameter int unsigned LEVELS          = 8,
	parameter int unsigned MIN_BLOCK_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	localparam int unsigned LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int unsigned OBW = $clog2(MIN_BLOCK_BYTES) + LEVELS + 1;
	localparam logic [OBW-1:0] REGION = OBW'(MIN_BLOCK_BYTES) << (LEVELS - 1);
	localparam int unsigned MINSH = $clog2(MIN_BLOCK_BYTES);
	localparam int unsigned REQ_W_L = bba_pkg::REQ_W;

	typedef enum logic [3:0] {
		S_IDLE, S_TGT, S_ARD, S_ACHK, S_SPLIT, S_FRD, S_FCHK,
		S_MRD, S_MCHK, S_RSP
	} state_t;

	state_t state_q;
	logic                 op_q;
	logic [REQ_W_L-1:0]   size_q;
	logic [OBW-1:0]       foff_q;
	logic [LW-1:0]        tgt_q, lvl_q;
	logic [LEVELS-1:0]    k_q, cur_q;
	logic                 ok_q;
	logic [bba_pkg::OFF_W-1:0] off_q;

	logic                we;
	logic [LEVELS-1:0]   waddr, raddr;
	bba_pkg::node_st_t   wdata, rdata;
	logic                init_done;

	bba_node_mem #(.LEVELS(LEVELS)) u_mem (
		.clk, .arst_n, .we, .waddr, .wdata, .raddr, .rdata, .init_done
	);

	// block size at level l
	function automatic logic [OBW-1:0] bsz(input logic [LW-1:0] l);
		return REGION >> l;
	endfunction

	function automatic logic [LEVELS-1:0] base(input logic [LW-1:0] l);
		return LEVELS'((1 << l) - 1);
	endfunction

	logic [LEVELS-1:0] idx_alloc, idx_free, buddy, parent;
	assign idx_alloc = base(lvl_q) + k_q;
	// block index of foff at level lvl: foff >> (MINSH + LEVELS-1-lvl)
	assign idx_free = base(lvl_q) +
		LEVELS'(foff_q >> (MINSH + LEVELS - 1 - 32'(lvl_q)));
	assign buddy  = cur_q[0] ? cur_q + 1'b1 : cur_q - 1'b1;
	assign parent = (cur_q - 1'b1) >> 1;

	logic free_aligned;
	assign free_aligned = (foff_q & (bsz(lvl_q) - 1'b1)) == '0;

	// single write per cycle; splits write node, then children in order
	logic [1:0] sub_q;

	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = cur_q;
		wdata = bba_pkg::ST_ABSENT;
		unique case (state_q)
			S_ARD:   raddr = idx_alloc;
			S_FRD:   raddr = idx_free;
			S_MRD:   raddr = buddy;
			S_SPLIT: begin
				we = 1'b1;
				unique case (sub_q)
					2'd0: begin waddr = cur_q; wdata = (lvl_q == tgt_q) ?
						bba_pkg::ST_ALLOC : bba_pkg::ST_SPLIT; end
					2'd1: begin
						waddr = LEVELS'(2 * cur_q + 1); wdata = bba_pkg::ST_FREE;
					end
					default: begin
						waddr = LEVELS'(2 * cur_q + 2); wdata = bba_pkg::ST_FREE;
					end
				endcase
			end
			S_FCHK: begin
				we = (rdata == bba_pkg::ST_ALLOC) && free_aligned &&
					(foff_q < REGION);
				waddr = idx_free; wdata = bba_pkg::ST_FREE;
			end
			S_MCHK: begin
				// keep reading the buddy so its status holds over the merge writes
				raddr = buddy;
				we = (rdata == bba_pkg::ST_FREE);
				unique case (sub_q)
					2'd0: begin waddr = cur_q; wdata = bba_pkg::ST_ABSENT; end
					2'd1: begin waddr = buddy; wdata = bba_pkg::ST_ABSENT; end
					default: begin waddr = parent; wdata = bba_pkg::ST_FREE; end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sub_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid && init_done) begin
					op_q   <= req.op;
					size_q <= req.req_size;
					foff_q <= OBW'(req.free_offset);
					ok_q   <= 1'b0;
					off_q  <= '0;
					sub_q  <= '0;
					tgt_q  <= LW'(LEVELS - 1);
					lvl_q  <= '0;
					state_q <= (req.op == bba_pkg::OP_FREE) ? S_FRD : S_TGT;
				end
				S_TGT: begin
					if (OBW'(size_q) > REGION) state_q <= S_RSP;
					else if (tgt_q != '0 && bsz(tgt_q) < OBW'(size_q))
						tgt_q <= tgt_q - 1'b1;
					else begin
						lvl_q <= tgt_q; k_q <= '0; state_q <= S_ARD;
					end
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (rdata == bba_pkg::ST_FREE) begin
						cur_q <= idx_alloc;
						off_q <= bba_pkg::OFF_W'(OBW'(k_q) * bsz(lvl_q));
						ok_q  <= 1'b1;
						sub_q <= '0;
						state_q <= S_SPLIT;
					end else if (k_q != LEVELS'((1 << lvl_q) - 1)) begin
						k_q <= k_q + 1'b1; state_q <= S_ARD;
					end else if (lvl_q != '0) begin
						lvl_q <= lvl_q - 1'b1; k_q <= '0; state_q <= S_ARD;
					end else state_q <= S_RSP;
				end
				S_SPLIT: begin
					if (lvl_q == tgt_q) state_q <= S_RSP;
					else if (sub_q == 2'd2) begin
						sub_q <= '0; cur_q <= LEVELS'(2 * cur_q + 1);
						lvl_q <= lvl_q + 1'b1;
					end else sub_q <= sub_q + 1'b1;
				end
				S_FRD: begin
					if (foff_q >= REGION) state_q <= S_RSP;
					else state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (we) begin
						ok_q <= 1'b1; cur_q <= idx_free; sub_q <= '0;
						state_q <= (lvl_q == '0) ? S_RSP : S_MRD;
					end else if (lvl_q != LW'(LEVELS - 1)) begin
						lvl_q <= lvl_q + 1'b1; state_q <= S_FRD;
					end else state_q <= S_RSP;
				end
				S_MRD: state_q <= S_MCHK;
				S_MCHK: begin
					if (rdata != bba_pkg::ST_FREE) state_q <= S_RSP;
					else if (sub_q != 2'd2) sub_q <= sub_q + 1'b1;
					else begin
						sub_q <= '0; cur_q <= parent; lvl_q <= lvl_q - 1'b1;
						state_q <= (lvl_q == LW'(1)) ? S_RSP : S_MRD;
					end
				end
				S_RSP: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE) && init_done;
	assign rsp.valid        = (state_q == S_RSP);
	assign rsp.success      = ok_q;
	assign rsp.block_offset = (op_q == bba_pkg::OP_ALLOC) ? off_q : '0;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready)
		else $error("request taken while busy");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(ok_q)))
		else $error("response dropped before transaction");
	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && op_q == bba_pkg::OP_FREE) |-> (rsp.block_offset == '0))
		else $error("free returned an offset");
`endif
endmodule

@@ rtl/core/bba_node_mem.sv @@
// ----------------------------------------------------------------------------
// bba_node_mem
// Node status store in heap order: one write port, one registered read port.
// A clearing pass after reset sets the root free and all others absent.
// ----------------------------------------------------------------------------
module bba_node_mem #(
	parameter int unsigned LEVELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [LEVELS-1:0]   waddr,
	input  bba_pkg::node_st_t   wdata,
	input  logic [LEVELS-1:0]   raddr,
	output bba_pkg::node_st_t   rdata,
	output logic                init_done
);
	localparam int unsigned NODES = (1 << LEVELS) - 1;

	bba_pkg::node_st_t mem [NODES];
	logic [LEVELS-1:0] clr_q;
	logic              busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LEVELS'(NODES - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= (clr_q == '0) ? bba_pkg::ST_FREE : bba_pkg::ST_ABSENT;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	assign init_done = !busy_q;
endmodule
